FILE: rtl/skf_pkg.sv
// Package for the scalar Kalman filter: controller states, datapath commands
// and configuration register indexes. No dependencies.
package skf_pkg;

  localparam int NumRegs = 7;
  localparam int RegIdxWidth = 3;

  localparam logic [RegIdxWidth-1:0] RegTransitionGain = 3'd0;
  localparam logic [RegIdxWidth-1:0] RegObservationGain = 3'd1;
  localparam logic [RegIdxWidth-1:0] RegProcessNoise = 3'd2;
  localparam logic [RegIdxWidth-1:0] RegMeasurementNoise = 3'd3;
  localparam logic [RegIdxWidth-1:0] RegInitialEstimate = 3'd4;
  localparam logic [RegIdxWidth-1:0] RegInitialCovariance = 3'd5;
  localparam logic [RegIdxWidth-1:0] RegMinInnovationVar = 3'd6;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,      // capture z, optionally reload state
    OP_X_AX,      // x  = A*x
    OP_T_AP,      // t  = A*P
    OP_T_TA,      // t  = t*A
    OP_P_TQ,      // p  = t+Q
    OP_T_HX,      // t  = H*x
    OP_Y_ZT,      // y  = z-t
    OP_T_HP,      // t  = H*p
    OP_T_TH,      // t  = t*H
    OP_S_TR,      // s  = t+R, fail check
    OP_N_PH,      // n  = p*H
    OP_DIV_START, // k  = n/s on the divider
    OP_T_KY,      // t  = k*y
    OP_X_XT,      // x  = x+t
    OP_T_KH,      // t  = k*H
    OP_T_1T,      // t  = 1-t
    OP_P_PT,      // p  = p*t
    OP_COMMIT     // state and result registers take x, p
  } skf_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PREDICT,
    ST_CHECK,
    ST_UPDATE,
    ST_COMMIT,
    ST_OUT
  } skf_state_t;

  // start launches the operation's unit, wr writes its result back.
  typedef struct packed {
    skf_op_t op;
    logic    start;
    logic    wr;
  } skf_cmd_t;

  typedef struct packed {
    logic fail;
    logic div_busy;
    logic mul_busy;
  } skf_status_t;

endpackage

FILE: rtl/skf_divider.sv
// Restoring divider for the gain: (|n| << FRAC_BITS) / |d|, one quotient bit
// per cycle, result saturated to the word. Uses skf_pkg for nothing.
module skf_divider #(
  parameter int WORD_WIDTH = 48,
  parameter int FRAC_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [WORD_WIDTH-1:0] num,
  input  logic signed [WORD_WIDTH-1:0] den,
  output logic                         busy,
  output logic signed [WORD_WIDTH-1:0] quot
);
  localparam int DivWidth = WORD_WIDTH + FRAC_BITS;
  localparam int CntWidth = $clog2(DivWidth + 1);

  logic [DivWidth-1:0] dividend;
  logic [DivWidth-1:0] q;
  logic [WORD_WIDTH:0] rem;
  logic [WORD_WIDTH:0] dmag;
  logic                neg;
  logic [CntWidth-1:0] count;
  logic [WORD_WIDTH:0] rem_sh;
  logic [WORD_WIDTH:0] nmag;
  logic [WORD_WIDTH:0] limit;
  logic                ovf;
  logic [WORD_WIDTH:0] qsat;

  assign nmag = num[WORD_WIDTH-1] ? -{num[WORD_WIDTH-1], num} : {1'b0, num};
  assign rem_sh = {rem[WORD_WIDTH-1:0], dividend[DivWidth-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CntWidth'(DivWidth);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CntWidth'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= {nmag[WORD_WIDTH-1:0], {FRAC_BITS{1'b0}}};
      dmag <= den[WORD_WIDTH-1] ? -{den[WORD_WIDTH-1], den} : {1'b0, den};
      neg <= num[WORD_WIDTH-1] ^ den[WORD_WIDTH-1];
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      dividend <= dividend << 1;
      if (rem_sh >= dmag) begin
        rem <= rem_sh - dmag;
        q <= {q[DivWidth-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q <= {q[DivWidth-2:0], 1'b0};
      end
    end
  end

  // Saturate the magnitude, then apply the sign.
  always_comb begin
    limit = {2'b00, {(WORD_WIDTH-1){1'b1}}} + {{WORD_WIDTH{1'b0}}, neg};
    ovf = (q[DivWidth-1:WORD_WIDTH+1] != '0) || (q[WORD_WIDTH:0] > limit);
    qsat = ovf ? limit : q[WORD_WIDTH:0];
    quot = neg ? WORD_WIDTH'(-qsat) : WORD_WIDTH'(qsat);
  end
endmodule

FILE: rtl/skf_datapath.sv
// Datapath of the scalar Kalman filter: one shared fixed-point multiplier,
// one saturating adder, the divider and the working registers. Uses skf_pkg.
module skf_datapath import skf_pkg::*; #(
  parameter int WORD_WIDTH = 48,
  parameter int FRAC_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  skf_cmd_t                     cmd,
  output skf_status_t                  status,
  input  logic [47:0]                  a_reg,
  input  logic [47:0]                  h_reg,
  input  logic [46:0]                  q_reg,
  input  logic [46:0]                  r_reg,
  input  logic [47:0]                  x0_reg,
  input  logic [46:0]                  p0_reg,
  input  logic [46:0]                  smin_reg,
  input  logic [47:0]                  z_in,
  input  logic                         restart_in,
  output logic [47:0]                  estimate,
  output logic [47:0]                  error_cov,
  output logic                         fail
);
  localparam int W = WORD_WIDTH;
  localparam int PW = 2 * W;
  localparam int MulChunks = (W + 15) / 16;
  localparam int MulBW = MulChunks * 16;
  localparam int MulCntW = $clog2(MulChunks + 1);
  localparam logic signed [W-1:0] WMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMin = {1'b1, {(W-1){1'b0}}};

  typedef logic signed [W-1:0] word_t;

  word_t est, cov, x, p, t, y, s, n, k, z;
  word_t m_a, m_b, mul_res, as_a, as_b, as_res;
  logic  as_sub;
  word_t a, h, q, r;
  word_t one;
  logic [W-1:0] am, bm, mul_ma;
  logic [MulBW-1:0] mul_mb;
  logic [W+15:0] mul_pp;
  logic [PW-1:0] acc, pshift;
  logic [W:0] plimit;
  logic mul_neg;
  logic mul_start;
  logic [MulCntW-1:0] mul_cnt;
  logic signed [W:0] sum;
  logic [W:0] smag;
  logic div_start;
  logic div_busy;
  logic fail_flag;

  // Bring a 48-bit source into the word, saturating when the word is narrower.
  function automatic word_t sat_in(input logic signed [64:0] v);
    logic signed [64:0] mx, mn;
    begin
      mx = 65'(WMax);
      mn = 65'(WMin);
      if (v > mx) sat_in = WMax;
      else if (v < mn) sat_in = WMin;
      else sat_in = W'(v);
    end
  endfunction

  assign a = sat_in(65'(signed'(a_reg)));
  assign h = sat_in(65'(signed'(h_reg)));
  assign q = sat_in(65'({1'b0, q_reg}));
  assign r = sat_in(65'({1'b0, r_reg}));
  assign one = sat_in(65'(1) <<< FRAC_BITS);

  // Operand selection for the shared multiplier and adder.
  always_comb begin
    m_a = a; m_b = x;
    as_a = t; as_b = q; as_sub = 1'b0;
    case (cmd.op)
      OP_X_AX: begin m_a = a; m_b = x; end
      OP_T_AP: begin m_a = a; m_b = p; end
      OP_T_TA: begin m_a = t; m_b = a; end
      OP_T_HX: begin m_a = h; m_b = x; end
      OP_T_HP: begin m_a = h; m_b = p; end
      OP_T_TH: begin m_a = t; m_b = h; end
      OP_N_PH: begin m_a = p; m_b = h; end
      OP_T_KY: begin m_a = k; m_b = y; end
      OP_T_KH: begin m_a = k; m_b = h; end
      OP_P_PT: begin m_a = p; m_b = t; end
      OP_P_TQ: begin as_a = t; as_b = q; end
      OP_Y_ZT: begin as_a = z; as_b = t; as_sub = 1'b1; end
      OP_S_TR: begin as_a = t; as_b = r; end
      OP_X_XT: begin as_a = x; as_b = t; end
      OP_T_1T: begin as_a = one; as_b = t; as_sub = 1'b1; end
      default: ;
    endcase
  end

  // Multiplier on magnitudes: the operands are captured at start, then one
  // 16-bit slice of the second operand is folded in per cycle, top slice
  // first. The exact product is ready when mul_cnt returns to zero.
  assign am = m_a[W-1] ? W'(-m_a) : W'(m_a);
  assign bm = m_b[W-1] ? W'(-m_b) : W'(m_b);
  assign mul_start = cmd.start && (cmd.op inside {OP_X_AX, OP_T_AP, OP_T_TA, OP_T_HX,
                                                  OP_T_HP, OP_T_TH, OP_N_PH, OP_T_KY,
                                                  OP_T_KH, OP_P_PT});
  assign mul_pp = (W+16)'(mul_ma) * (W+16)'(mul_mb[MulBW-1 -: 16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_cnt <= '0;
    end else if (mul_start) begin
      mul_ma <= am;
      mul_mb <= MulBW'(bm);
      mul_neg <= m_a[W-1] ^ m_b[W-1];
      acc <= '0;
      mul_cnt <= MulCntW'(MulChunks);
    end else if (mul_cnt != '0) begin
      acc <= (acc << 16) + PW'(mul_pp);
      mul_mb <= mul_mb << 16;
      mul_cnt <= mul_cnt - 1'b1;
    end
  end

  // Product truncated toward zero, then saturated.
  always_comb begin
    pshift = acc >> FRAC_BITS;
    plimit = {2'b00, {(W-1){1'b1}}} + {{W{1'b0}}, mul_neg};
    if (pshift[PW-1:W+1] != '0 || pshift[W:0] > plimit) pshift = PW'(plimit);
    mul_res = mul_neg ? W'(-pshift[W:0]) : W'(pshift[W:0]);
  end

  always_comb begin
    sum = as_sub ? ((W+1)'(as_a) - (W+1)'(as_b)) : ((W+1)'(as_a) + (W+1)'(as_b));
    if (sum > (W+1)'(WMax)) as_res = WMax;
    else if (sum < (W+1)'(WMin)) as_res = WMin;
    else as_res = W'(sum);
  end

  assign div_start = cmd.start && (cmd.op == OP_DIV_START);

  skf_divider #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(n), .den(s),
    .busy(div_busy), .quot(k)
  );

  assign status = {fail_flag, div_busy, (mul_cnt != '0)};

  // Magnitude of the new innovation variance for the minimum check.
  assign smag = as_res[W-1] ? (W+1)'(-(W+1)'(as_res)) : (W+1)'(as_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
      cov <= '0;
      fail_flag <= 1'b0;
    end else if (cmd.wr) begin
      case (cmd.op)
        OP_LOAD: begin
          z <= sat_in(65'(signed'(z_in)));
          if (restart_in) begin
            x <= sat_in(65'(signed'(x0_reg)));
            p <= sat_in(65'({1'b0, p0_reg}));
          end else begin
            x <= est;
            p <= cov;
          end
        end
        OP_X_AX: x <= mul_res;
        OP_T_AP, OP_T_TA, OP_T_HX, OP_T_HP, OP_T_TH, OP_T_KY, OP_T_KH:
          t <= mul_res;
        OP_P_TQ: p <= as_res;
        OP_Y_ZT: y <= as_res;
        OP_S_TR: begin
          s <= as_res;
          fail_flag <= (as_res == '0) || (65'(smag) < 65'({1'b0, smin_reg}));
        end
        OP_N_PH: n <= mul_res;
        OP_X_XT: x <= as_res;
        OP_T_1T: t <= as_res;
        OP_P_PT: p <= mul_res;
        OP_COMMIT: begin
          est <= x;
          cov <= p;
          estimate <= 48'(x);
          error_cov <= 48'(p);
          fail <= fail_flag;
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/skf_controller.sv
// Controller of the scalar Kalman filter: sequences datapath operations for
// one word and runs the handshakes. Uses skf_pkg.
module skf_controller import skf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output skf_cmd_t    cmd,
  input  skf_status_t status
);
  localparam logic [3:0] LastPredictStep = 4'd8;
  localparam logic [3:0] LastUpdateStep = 4'd6;

  skf_state_t state, state_next;
  logic [3:0] step, step_next;
  // Each step first issues its operation, then waits for the units and writes back.
  logic       phase, phase_next;
  logic       units_idle;

  assign units_idle = !status.mul_busy && !status.div_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next = step;
    phase_next = phase;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_LOAD;
      ST_LOAD: begin
        state_next = ST_PREDICT;
        step_next = '0;
        phase_next = 1'b0;
      end
      ST_PREDICT, ST_UPDATE: begin
        if (!phase) begin
          phase_next = 1'b1;
        end else if (units_idle) begin
          phase_next = 1'b0;
          step_next = step + 1'b1;
          if (state == ST_PREDICT && step == LastPredictStep) begin
            state_next = ST_CHECK;
            step_next = '0;
          end else if (state == ST_UPDATE && step == LastUpdateStep) begin
            state_next = ST_COMMIT;
            step_next = '0;
          end
        end
      end
      ST_CHECK: begin
        step_next = '0;
        phase_next = 1'b0;
        if (status.fail) state_next = ST_COMMIT;
        else state_next = ST_UPDATE;
      end
      ST_COMMIT: state_next = ST_OUT;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    cmd.start = 1'b0;
    cmd.wr = 1'b0;
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    case (state)
      ST_LOAD: begin
        cmd.op = OP_LOAD;
        cmd.wr = 1'b1;
      end
      ST_PREDICT: begin
        case (step)
          4'd0: cmd.op = OP_X_AX;
          4'd1: cmd.op = OP_T_AP;
          4'd2: cmd.op = OP_T_TA;
          4'd3: cmd.op = OP_P_TQ;
          4'd4: cmd.op = OP_T_HX;
          4'd5: cmd.op = OP_Y_ZT;
          4'd6: cmd.op = OP_T_HP;
          4'd7: cmd.op = OP_T_TH;
          default: cmd.op = OP_S_TR;
        endcase
        cmd.start = !phase;
        cmd.wr = phase && units_idle;
      end
      ST_UPDATE: begin
        case (step)
          4'd0: cmd.op = OP_N_PH;
          4'd1: cmd.op = OP_DIV_START;
          4'd2: cmd.op = OP_T_KY;
          4'd3: cmd.op = OP_X_XT;
          4'd4: cmd.op = OP_T_KH;
          4'd5: cmd.op = OP_T_1T;
          default: cmd.op = OP_P_PT;
        endcase
        cmd.start = !phase;
        cmd.wr = phase && units_idle;
      end
      ST_COMMIT: begin
        cmd.op = OP_COMMIT;
        cmd.wr = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/scalar_kalman_filter.sv
// Scalar Kalman filter top level: configuration registers, controller and
// datapath. Uses skf_pkg, skf_controller, skf_datapath.
// The result word follows load, ten multiplies, five adds, a division, the
// check and commit; when the variance check fails, the update is skipped and
// the result is committed right after the check. A new input word is accepted
// only after the previous result is taken. Reset loads defaults, clears state.
module scalar_kalman_filter import skf_pkg::*; #(
  parameter int WORD_WIDTH = 48,
  parameter int FRAC_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] measurement,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] estimate,
  output logic [47:0] error_cov,
  output logic        fail
);
  logic [47:0] a_reg, h_reg, x0_reg;
  logic [46:0] q_reg, r_reg, p0_reg, smin_reg;
  skf_cmd_t    cmd;
  skf_status_t status;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_reg <= 48'd4294967296;
      h_reg <= 48'd4294967296;
      q_reg <= 47'd429497;
      r_reg <= 47'd10737418;
      x0_reg <= '0;
      p0_reg <= '0;
      smin_reg <= 47'd43;
    end else if (cfg_we) begin
      case (cfg_index)
        RegTransitionGain: a_reg <= cfg_data;
        RegObservationGain: h_reg <= cfg_data;
        RegProcessNoise: q_reg <= cfg_data[46:0];
        RegMeasurementNoise: r_reg <= cfg_data[46:0];
        RegInitialEstimate: x0_reg <= cfg_data;
        RegInitialCovariance: p0_reg <= cfg_data[46:0];
        RegMinInnovationVar: smin_reg <= cfg_data[46:0];
        default: ;
      endcase
    end
  end

  // The input word is held by the sender until accepted; the datapath
  // captures it in the load step right after acceptance, while valid is
  // already dropped possibly, so latch it at acceptance.
  logic [47:0] z_hold;
  logic        rs_hold;
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      z_hold <= measurement;
      rs_hold <= restart;
    end
  end

  skf_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .status(status)
  );

  skf_datapath #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .a_reg(a_reg), .h_reg(h_reg), .q_reg(q_reg), .r_reg(r_reg),
    .x0_reg(x0_reg), .p0_reg(p0_reg), .smin_reg(smin_reg),
    .z_in(z_hold), .restart_in(rs_hold),
    .estimate(estimate), .error_cov(error_cov), .fail(fail)
  );
endmodule
